>>> rtl/core/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned HEAP_WORDS_DEF = 32768;
  localparam int unsigned BYTES_PER_WORD = 6;
  localparam logic [15:0] LIMIT_RESET    = 16'o070000;
  localparam logic [16:0] MIN_SPLIT      = 17'd2;
  localparam logic [15:0] NONE_MARK      = 16'h8000;
  localparam logic [16:0] ADDR_SPAN      = 17'h08000;
  localparam int unsigned IN_TDATA_W     = 40;
  localparam int unsigned OUT_TDATA_W    = 40;
  // Reciprocal of six scaled by two to the twentieth, rounded up.
  localparam logic [17:0] RECIP_SIX      = 18'd174763;

  typedef enum logic [0:0] {
    REG_HEAP_BASE = 1'b0,
    REG_HEAP_END  = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_FREE    = 3'd1,
    OP_REALLOC = 3'd2,
    OP_QFREE   = 3'd3,
    OP_QSIZE   = 3'd4
  } opcode_e;

  typedef enum logic [5:0] {
    S_IDLE, S_WORDS, S_DISP, S_CLAIM, S_CLAIM2, S_CLAIMED,
    S_TW_CHK, S_TW_SZ, S_TW_NXT, S_NS_R, S_SP_W1, S_SP_W2, S_SP_R3,
    S_SP_W4, S_SP_LINK, S_TW_RH, S_TW_SUB, S_GRANTED,
    S_RL_RD0, S_RL_TOT, S_RL_CHK, S_RL_TLINK, S_RL_TW, S_RL_HS,
    S_RL_NRD, S_RL_NXT, S_M_RN, S_M_W, S_M_RN1, S_M_N, S_M_RH, S_M_RH2,
    S_M_RNN, S_M_W2, S_M_RN1B, S_M_W3, S_I_LINK, S_I_RNH, S_I_RH,
    S_I_CMP, S_I_RH1, S_I_W, S_RA_RD, S_RA_CHK, S_SZ_RD, S_SZ_MUL, S_DONE
  } state_e;

  typedef struct packed {
    logic        status;
    logic [14:0] payload_address;
    logic [17:0] byte_count;
    logic        moved;
  } result_t;

  function automatic logic [17:0] times_six(input logic [15:0] v);
    logic [18:0] s;
    s = {v, 2'b00} + {1'b0, v, 1'b0};
    return s[17:0];
  endfunction

endpackage

>>> rtl/core/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator: sequencer, registers and ports.
//
//  channel   | direction | fields (low bit up)
//  s_axis    | in        | tdata: opcode[3] request_bytes[18] block_address[15]
//  m_axis    | out       | tdata: status[1] payload_address[15] byte_count[18] moved[1]
//  cfg       | in        | write enable, index 0 heap_base, index 1 heap end
//
// One sequencer steps a single-port metadata memory, one access per cycle unless a
// result waits for the output register; a word is taken only in the idle state. An
// allocate walks the free list for the first block that fits and splits it when it
// is large enough; a free walks the list to insert the block and merge neighbours.
// The first allocate, reallocate or free-bytes query sets up the heap.
// A finished result holds the sequencer until it can enter the output register.
module first_fit_heap_allocator_unit #(
  parameter int unsigned HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // opcode[2:0], request_bytes[20:3], block_address[35:21], zeros above
  input  logic [ffha_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // status[0], payload_address[15:1], byte_count[33:16], moved[34], zeros above
  output logic [ffha_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_addr_i,
  input  logic [15:0]                        cfg_wdata_i
);
  import ffha_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_WORDS);
  localparam logic [16:0] HW17 = 17'(HEAP_WORDS);

  state_e state_q, state_d;
  logic [2:0]  op_q, op_d;
  logic [17:0] nbytes_q, nbytes_d;
  logic [14:0] ptr_q, ptr_d;
  logic [15:0] nw_q, nw_d;
  logic [16:0] nwt_q, nwt_d;
  logic [15:0] h_q, h_d, prev_q, prev_d, sz_q, sz_d, nh_q, nh_d, a_q, a_d, t_q, t_d;
  logic [16:0] steps_q, steps_d;
  logic [15:0] head_q, head_d, total_q, total_d;
  logic        setup_q, setup_d;
  logic [14:0] base_q;
  logic [15:0] limit_q;
  result_t     res_q, res_d;
  logic        ovalid_q;
  result_t     out_q;

  logic          mem_we;
  logic [16:0]   mem_a;
  logic [15:0]   mem_wd, mem_rd;
  logic [15:0]   words;
  logic [16:0]   lim;
  logic          claim_ok;
  logic [15:0]   span_words;
  logic          out_free;

  ffha_meta_ram #(.AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_a[AW-1:0]),
    .wdata_i (mem_wd),
    .rdata_o (mem_rd)
  );

  ffha_words u_words (
    .clk_i   (clk_i),
    .bytes_i (nbytes_q),
    .words_o (words)
  );

  always_comb begin
    lim = {1'b0, limit_q};
    if (lim > ADDR_SPAN) lim = ADDR_SPAN;
    if (lim > HW17)      lim = HW17;
  end
  assign claim_ok   = {2'b00, base_q} < lim;
  assign span_words = 16'(lim - {2'b00, base_q});
  assign out_free   = !ovalid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);

  // Next state and working registers.
  always_comb begin
    state_d = state_q;
    op_d = op_q; nbytes_d = nbytes_q; ptr_d = ptr_q; nw_d = nw_q; nwt_d = nwt_q;
    h_d = h_q; prev_d = prev_q; sz_d = sz_q; nh_d = nh_q; a_d = a_q; t_d = t_q;
    steps_d = steps_q; head_d = head_q; total_d = total_q; setup_d = setup_q;
    res_d = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d     = s_axis_tdata_i[2:0];
          nbytes_d = s_axis_tdata_i[20:3];
          ptr_d    = s_axis_tdata_i[35:21];
          state_d  = S_WORDS;
        end
      end
      S_WORDS: state_d = S_DISP;
      S_DISP: begin
        nw_d  = words;
        nwt_d = (words == 16'd0) ? 17'd2 : {1'b0, words} + 17'd1;
        res_d = '0;
        priority case (op_q)
          OP_ALLOC, OP_QFREE: state_d = S_CLAIM;
          OP_FREE: begin
            nh_d    = {1'b0, ptr_q} - 16'd1;
            state_d = (ptr_q != '0) ? S_RL_RD0 : S_DONE;
          end
          OP_REALLOC: state_d = (ptr_q != '0) ? S_RA_RD : S_CLAIM;
          OP_QSIZE:   state_d = (ptr_q != '0) ? S_SZ_RD : S_DONE;
          default:    state_d = S_DONE;
        endcase
      end
      S_CLAIM: begin
        if (!setup_q) begin
          setup_d = 1'b1;
          if (claim_ok) begin
            head_d  = {1'b0, base_q};
            total_d = span_words;
            state_d = S_CLAIM2;
          end else begin
            state_d = S_CLAIMED;
          end
        end else begin
          state_d = S_CLAIMED;
        end
      end
      S_CLAIM2: state_d = S_CLAIMED;
      S_CLAIMED: begin
        if (op_q == OP_QFREE) begin
          res_d.byte_count = times_six(total_q);
          state_d = S_DONE;
        end else begin
          h_d = head_q; prev_d = NONE_MARK; steps_d = '0;
          state_d = S_TW_CHK;
        end
      end
      S_TW_CHK: begin
        if (h_q == NONE_MARK || steps_q > HW17) begin
          res_d.payload_address = '0;
          state_d = S_GRANTED;
        end else begin
          steps_d = steps_q + 17'd1;
          state_d = S_TW_SZ;
        end
      end
      S_TW_SZ: begin
        sz_d = mem_rd;
        if ({1'b0, mem_rd} >= nwt_q) begin
          if ({1'b0, mem_rd} >= nwt_q + MIN_SPLIT) begin
            nh_d    = h_q + nwt_q[15:0];
            state_d = S_SP_W1;
          end else begin
            state_d = S_NS_R;
          end
        end else begin
          prev_d  = h_q;
          state_d = S_TW_NXT;
        end
      end
      S_TW_NXT: begin
        h_d = mem_rd;
        state_d = S_TW_CHK;
      end
      S_NS_R: begin
        if (prev_q == NONE_MARK) head_d = mem_rd;
        state_d = S_TW_RH;
      end
      S_SP_W1: state_d = S_SP_W2;
      S_SP_W2: state_d = S_SP_R3;
      S_SP_R3: state_d = S_SP_W4;
      S_SP_W4: state_d = S_SP_LINK;
      S_SP_LINK: begin
        if (prev_q == NONE_MARK) head_d = nh_q;
        state_d = S_TW_RH;
      end
      S_TW_RH: state_d = S_TW_SUB;
      S_TW_SUB: begin
        total_d = total_q - mem_rd;
        res_d.payload_address = 15'(h_q + 16'd1);
        state_d = S_GRANTED;
      end
      S_GRANTED: begin
        res_d.status = (res_q.payload_address == '0);
        if (op_q == OP_REALLOC && ptr_q != '0 && res_q.payload_address != '0) begin
          res_d.moved = 1'b1;
          nh_d    = {1'b0, ptr_q} - 16'd1;
          state_d = S_RL_RD0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RL_RD0: state_d = S_RL_TOT;
      S_RL_TOT: begin
        total_d = total_q + mem_rd;
        h_d = head_q; prev_d = NONE_MARK; steps_d = '0;
        state_d = S_RL_CHK;
      end
      S_RL_CHK: begin
        if (h_q == NONE_MARK) begin
          state_d = S_RL_TLINK;
        end else if (steps_q > HW17) begin
          state_d = S_DONE;
        end else begin
          steps_d = steps_q + 17'd1;
          state_d = (h_q > nh_q) ? S_I_LINK : S_RL_HS;
        end
      end
      S_RL_TLINK: begin
        if (prev_q == NONE_MARK) head_d = nh_q;
        state_d = S_RL_TW;
      end
      S_RL_TW: state_d = S_DONE;
      S_RL_HS: begin
        a_d = mem_rd;
        if ({1'b0, h_q} + {1'b0, mem_rd} == {1'b0, nh_q}) begin
          state_d = S_M_RN;
        end else begin
          prev_d  = h_q;
          state_d = S_RL_NRD;
        end
      end
      S_RL_NRD: state_d = S_RL_NXT;
      S_RL_NXT: begin
        h_d = mem_rd;
        state_d = S_RL_CHK;
      end
      S_M_RN:  state_d = S_M_W;
      S_M_W:   state_d = S_M_RN1;
      S_M_RN1: state_d = S_M_N;
      S_M_N: begin
        t_d = mem_rd;
        state_d = (mem_rd != NONE_MARK) ? S_M_RH : S_DONE;
      end
      S_M_RH: state_d = S_M_RH2;
      S_M_RH2: begin
        a_d = mem_rd;
        state_d = ({1'b0, h_q} + {1'b0, mem_rd} == {1'b0, t_q}) ? S_M_RNN : S_DONE;
      end
      S_M_RNN:  state_d = S_M_W2;
      S_M_W2:   state_d = S_M_RN1B;
      S_M_RN1B: state_d = S_M_W3;
      S_M_W3:   state_d = S_DONE;
      S_I_LINK: begin
        if (prev_q == NONE_MARK) head_d = nh_q;
        state_d = S_I_RNH;
      end
      S_I_RNH: state_d = S_I_RH;
      S_I_RH: begin
        a_d = mem_rd;
        state_d = S_I_CMP;
      end
      S_I_CMP: begin
        state_d = ({1'b0, nh_q} + {1'b0, a_q} == {1'b0, h_q}) ? S_I_RH1 : S_DONE;
      end
      S_I_RH1: state_d = S_I_W;
      S_I_W:   state_d = S_DONE;
      S_RA_RD: state_d = S_RA_CHK;
      S_RA_CHK: begin
        if (mem_rd - 16'd1 >= nw_q) begin
          res_d.payload_address = ptr_q;
          state_d = S_DONE;
        end else begin
          state_d = S_CLAIM;
        end
      end
      S_SZ_RD: state_d = S_SZ_MUL;
      S_SZ_MUL: begin
        res_d.byte_count = times_six(mem_rd - 16'd1);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Metadata memory access of each state.
  always_comb begin
    mem_we = 1'b0;
    mem_a  = {1'b0, h_q};
    mem_wd = '0;
    unique case (state_q)
      S_CLAIM: begin
        mem_a  = {2'b00, base_q};
        mem_wd = span_words;
        mem_we = !setup_q && claim_ok;
      end
      S_CLAIM2: begin
        mem_a  = {2'b00, base_q} + 17'd1;
        mem_wd = NONE_MARK;
        mem_we = 1'b1;
      end
      S_TW_SZ, S_SP_R3, S_RL_NRD, S_M_RN1, S_I_RH1: mem_a = {1'b0, h_q} + 17'd1;
      S_NS_R: begin
        mem_a  = {1'b0, prev_q} + 17'd1;
        mem_wd = mem_rd;
        mem_we = (prev_q != NONE_MARK);
      end
      S_SP_W1: begin
        mem_a  = {1'b0, nh_q};
        mem_wd = sz_q - nwt_q[15:0];
        mem_we = 1'b1;
      end
      S_SP_W2: begin
        mem_wd = nwt_q[15:0];
        mem_we = 1'b1;
      end
      S_SP_W4: begin
        mem_a  = {1'b0, nh_q} + 17'd1;
        mem_wd = mem_rd;
        mem_we = 1'b1;
      end
      S_SP_LINK, S_RL_TLINK, S_I_LINK: begin
        mem_a  = {1'b0, prev_q} + 17'd1;
        mem_wd = nh_q;
        mem_we = (prev_q != NONE_MARK);
      end
      S_RL_RD0, S_M_RN, S_I_RNH: mem_a = {1'b0, nh_q};
      S_RL_TW: begin
        mem_a  = {1'b0, nh_q} + 17'd1;
        mem_wd = NONE_MARK;
        mem_we = 1'b1;
      end
      S_M_W, S_M_W2: begin
        mem_wd = a_q + mem_rd;
        mem_we = 1'b1;
      end
      S_M_RNN:  mem_a = {1'b0, t_q};
      S_M_RN1B: mem_a = {1'b0, t_q} + 17'd1;
      S_M_W3: begin
        mem_a  = {1'b0, h_q} + 17'd1;
        mem_wd = mem_rd;
        mem_we = 1'b1;
      end
      S_I_CMP: begin
        if ({1'b0, nh_q} + {1'b0, a_q} == {1'b0, h_q}) begin
          mem_a  = {1'b0, nh_q};
          mem_wd = a_q + mem_rd;
        end else begin
          mem_a  = {1'b0, nh_q} + 17'd1;
          mem_wd = h_q;
        end
        mem_we = 1'b1;
      end
      S_I_W: begin
        mem_a  = {1'b0, nh_q} + 17'd1;
        mem_wd = mem_rd;
        mem_we = 1'b1;
      end
      S_RA_RD, S_SZ_RD: mem_a = {2'b00, ptr_q} - 17'd1;
      default: mem_a = {1'b0, h_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= NONE_MARK;
      total_q  <= '0;
      setup_q  <= 1'b0;
      base_q   <= '0;
      limit_q  <= LIMIT_RESET;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      total_q <= total_d;
      setup_q <= setup_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_addr_i))
          REG_HEAP_BASE: base_q  <= cfg_wdata_i[14:0];
          REG_HEAP_END:  limit_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == S_DONE && out_free) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; nbytes_q <= nbytes_d; ptr_q <= ptr_d; nw_q <= nw_d; nwt_q <= nwt_d;
    h_q <= h_d; prev_q <= prev_d; sz_q <= sz_d; nh_q <= nh_d; a_q <= a_d; t_q <= t_d;
    steps_q <= steps_d;
    res_q <= res_d;
    if (state_q == S_DONE && out_free) out_q <= res_q;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {5'b0, out_q.moved, out_q.byte_count,
                            out_q.payload_address, out_q.status};
endmodule

>>> rtl/core/ffha_meta_ram.sv
// Metadata memory: one port, registered read data.
module ffha_meta_ram #(
  parameter int unsigned AW = 15
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [15:0]   wdata_i,
  output logic [15:0]   rdata_o
);
  logic [15:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

>>> rtl/core/ffha_words.sv
// Byte count to six-byte words, rounded up, by a registered reciprocal multiply.
module ffha_words (
  input  logic        clk_i,
  input  logic [17:0] bytes_i,
  output logic [15:0] words_o
);
  import ffha_pkg::*;

  logic [36:0] prod_q, prod_d;

  always_comb begin
    prod_d = 37'({1'b0, bytes_i} + 19'd5) * 37'(RECIP_SIX);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign words_o = prod_q[35:20];
endmodule

>>> rtl/core/ffha_checker.sv
// Port-level checks of the heap allocator, bound to the top level.
module ffha_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a request is in work");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |->
      m_axis_tdata_o[15:1] == 15'd0 && !m_axis_tdata_o[34])
    else $error("failed request reports an address or a move");

  a_moved_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[34] |->
      !m_axis_tdata_o[0] && m_axis_tdata_o[15:1] != 15'd0)
    else $error("moved block without a granted address");
endmodule

bind first_fit_heap_allocator_unit ffha_assert u_ffha_assert (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
